FILE: design/fla_pkg.sv
package fla_pkg;

  localparam int PAGE_W   = 12;
  localparam int COUNT_W  = 13;
  localparam int STATUS_W = 2;

  typedef enum logic [0:0] {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  typedef struct packed {
    op_t               operation;
    logic [PAGE_W-1:0] page_number;
  } in_word_t;

  typedef struct packed {
    logic [PAGE_W-1:0]  allocated_page;
    status_t            status;
    logic [COUNT_W-1:0] page_count;
  } out_word_t;

endpackage

FILE: design/fla_ram.sv
module fla_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: design/free_list_page_allocator_unit.sv
// Free-list page allocator.
// Input channel (in_valid / in_stall / in_data): one word per request, either
// allocate a page or free in_data.page_number. Result channel (out_valid /
// out_stall / out_data): exactly one word per request, in request order.
// The next-pointer of every page sits in one RAM with a registered read; the
// head page and page count are registers.
// Free and a full allocate register their result on the accept; an allocate
// from a non-empty list first goes to S_READ for the RAM read of the head's
// link. An allocate on an empty list first walks the new pages in S_GROW,
// one RAM write a cycle, then passes through S_POP and S_READ.
// One request is in flight at a time; a free can be taken every cycle while
// out_stall lets the result go, an allocate only after S_READ is done.
// After reset the RAM is loaded with the initial descending chain, one entry
// a cycle, for min(INITIAL_PAGES, MAX_PAGES) entries; in_stall stays high
// meanwhile.
// A result held by out_stall keeps in_stall high, so no further request is
// taken until the held word has gone.
module free_list_page_allocator_unit #(
  parameter int MAX_PAGES     = 4096,
  parameter int INITIAL_PAGES = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  fla_pkg::in_word_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output fla_pkg::out_word_t  out_data
);
  import fla_pkg::*;

  localparam int PW = $clog2(MAX_PAGES);
  localparam int CW = $clog2(MAX_PAGES + 1);
  localparam int N0 = (INITIAL_PAGES > MAX_PAGES) ? MAX_PAGES : INITIAL_PAGES;
  localparam int XW = (PAGE_W > CW) ? PAGE_W : CW;

  typedef enum logic [5:0] {
    S_INIT = 6'b000001,
    S_IDLE = 6'b000010,
    S_GROW = 6'b000100,
    S_POP  = 6'b001000,
    S_READ = 6'b010000,
    S_SPARE = 6'b100000
  } state_t;

  state_t          state_r, state_nxt;
  logic [PW-1:0]   head_r, head_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [PW-1:0]   init_r, init_nxt;
  logic [PW-1:0]   walk_r, walk_nxt;
  logic [CW-1:0]   grown_r, grown_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_word_t       out_data_r, out_data_nxt;

  logic            wr_en;
  logic [PW-1:0]   wr_addr;
  logic [PW-1:0]   wr_data;
  logic [PW-1:0]   rd_data;

  logic            slot_free;
  logic            accept;
  logic            page_bad;
  logic [CW:0]     dbl;
  logic [CW-1:0]   grown_calc;

  fla_ram #(
    .WIDTH (PW),
    .DEPTH (MAX_PAGES)
  ) u_links (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (head_r),
    .rd_data (rd_data)
  );

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == S_IDLE) && slot_free);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign page_bad = (in_data.page_number == '0) ||
                    (XW'(in_data.page_number) >= XW'(count_r));
  assign dbl        = {count_r, 1'b0};
  assign grown_calc = (dbl > (CW+1)'(MAX_PAGES)) ? CW'(MAX_PAGES) : dbl[CW-1:0];

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    init_nxt      = init_r;
    walk_nxt      = walk_r;
    grown_nxt     = grown_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    wr_addr       = init_r;
    wr_data       = '0;

    unique case (state_r)
      S_INIT: begin
        wr_en    = 1'b1;
        wr_addr  = init_r;
        wr_data  = (init_r == '0) ? '0 : init_r - PW'(1);
        init_nxt = init_r + PW'(1);
        if (init_r == PW'(N0 - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (in_data.operation == OP_FREE) begin
            out_valid_nxt               = 1'b1;
            out_data_nxt.allocated_page = '0;
            out_data_nxt.page_count     = COUNT_W'(count_r);
            if (page_bad) begin
              out_data_nxt.status = ST_INVALID;
            end else begin
              out_data_nxt.status = ST_OK;
              wr_en    = 1'b1;
              wr_addr  = PW'(in_data.page_number);
              wr_data  = head_r;
              head_nxt = PW'(in_data.page_number);
            end
          end else if (head_r != '0) begin
            state_nxt = S_READ;
          end else if (count_r == CW'(MAX_PAGES)) begin
            out_valid_nxt               = 1'b1;
            out_data_nxt.allocated_page = '0;
            out_data_nxt.status         = ST_FULL;
            out_data_nxt.page_count     = COUNT_W'(count_r);
          end else begin
            grown_nxt = grown_calc;
            walk_nxt  = PW'(count_r);
            state_nxt = S_GROW;
          end
        end
      end
      S_GROW: begin
        // old count terminates the new chain, the rest point one page down
        wr_en    = 1'b1;
        wr_addr  = walk_r;
        wr_data  = (walk_r == PW'(count_r)) ? '0 : walk_r - PW'(1);
        walk_nxt = walk_r + PW'(1);
        if (walk_r == PW'(grown_r - CW'(1))) begin
          count_nxt = grown_r;
          head_nxt  = PW'(grown_r - CW'(1));
          state_nxt = S_POP;
        end
      end
      S_POP: begin
        // RAM read of the new head's link is issued here
        state_nxt = S_READ;
      end
      S_READ: begin
        head_nxt                    = rd_data;
        out_valid_nxt               = 1'b1;
        out_data_nxt.allocated_page = PAGE_W'(head_r);
        out_data_nxt.status         = ST_OK;
        out_data_nxt.page_count     = COUNT_W'(count_r);
        state_nxt                   = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      head_r      <= PW'(N0 - 1);
      count_r     <= CW'(N0);
      init_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      init_r      <= init_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    walk_r     <= walk_nxt;
    grown_r    <= grown_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
